// ----- sv/lppd_pkg.sv -----
package lppd_pkg;

  // Field widths of the byte stream, the frame header and the result kind.
  localparam int unsigned ByteW = 8;
  localparam int unsigned LenW  = 16;
  localparam int unsigned KindW = 2;

  // The shortest legal frame is the two header bytes alone.
  localparam logic [LenW-1:0] MinTotalLen   = LenW'(2);
  localparam logic [LenW-1:0] MaxLenDefault = '1;

  // Result kinds.
  typedef enum logic [KindW-1:0] {
    KIND_BODY  = 2'd0,
    KIND_EMPTY = 2'd1,
    KIND_ERROR = 2'd2
  } kind_t;

  // One result transaction.
  typedef struct packed {
    kind_t            kind;
    logic [ByteW-1:0] body_byte;
    logic             first_of_packet;
    logic             last_of_packet;
  } result_t;

  // Handoff from the parser to the result register.
  typedef struct packed {
    logic    emit;
    result_t res;
  } parse_out_t;

endpackage

// ----- sv/lppd_in_reg.sv -----
module lppd_in_reg (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [lppd_pkg::ByteW-1:0] in_byte,
  input  logic                      advance,
  output logic                      hold_valid,
  output logic [lppd_pkg::ByteW-1:0] hold_byte
);
  import lppd_pkg::*;

  // The register can take a new byte when it is empty or being drained.
  assign in_ready = !hold_valid || advance;

  // Occupancy flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_ready) begin
      hold_valid <= in_valid;
    end
  end

  // Captured byte.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      hold_byte <= in_byte;
    end
  end

endmodule

// ----- sv/lppd_parse.sv -----
module lppd_parse (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       advance,
  input  logic [lppd_pkg::ByteW-1:0] cur_byte,
  input  logic [lppd_pkg::LenW-1:0]  max_len,
  output lppd_pkg::parse_out_t       pout
);
  import lppd_pkg::*;

  logic             in_body, in_body_next;
  logic             have_low_byte, have_low_byte_next;
  logic [ByteW-1:0] length_low_byte, length_low_byte_next;
  logic [LenW-1:0]  bytes_left, bytes_left_next;
  logic             at_packet_start, at_packet_start_next;
  logic             halted, halted_next;
  logic [LenW-1:0]  total;
  logic             last;

  assign total = {cur_byte, length_low_byte};
  assign last  = (bytes_left <= LenW'(1));

  // Framing decision for the byte at the head of the input register.
  always_comb begin
    in_body_next         = in_body;
    have_low_byte_next   = have_low_byte;
    length_low_byte_next = length_low_byte;
    bytes_left_next      = bytes_left;
    at_packet_start_next = at_packet_start;
    halted_next          = halted;
    pout                 = '0;
    pout.res.kind        = KIND_BODY;

    if (halted) begin
      // Everything after a bad length is dropped.
    end else if (in_body) begin
      pout.emit                 = 1'b1;
      pout.res.kind             = KIND_BODY;
      pout.res.body_byte        = cur_byte;
      pout.res.first_of_packet  = at_packet_start;
      pout.res.last_of_packet   = last;
      at_packet_start_next      = 1'b0;
      bytes_left_next           = last ? '0 : bytes_left - LenW'(1);
      in_body_next              = !last;
    end else if (!have_low_byte) begin
      length_low_byte_next = cur_byte;
      have_low_byte_next   = 1'b1;
    end else begin
      have_low_byte_next   = 1'b0;
      length_low_byte_next = '0;
      if (total < MinTotalLen || total > max_len) begin
        halted_next   = 1'b1;
        pout.emit     = 1'b1;
        pout.res.kind = KIND_ERROR;
      end else if (total == MinTotalLen) begin
        pout.emit               = 1'b1;
        pout.res.kind           = KIND_EMPTY;
        pout.res.last_of_packet = 1'b1;
      end else begin
        bytes_left_next      = total - MinTotalLen;
        in_body_next         = 1'b1;
        at_packet_start_next = 1'b1;
      end
    end
  end

  // Framing state moves only when a byte leaves the input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_body         <= 1'b0;
      have_low_byte   <= 1'b0;
      length_low_byte <= '0;
      bytes_left      <= '0;
      at_packet_start <= 1'b0;
      halted          <= 1'b0;
    end else if (advance) begin
      in_body         <= in_body_next;
      have_low_byte   <= have_low_byte_next;
      length_low_byte <= length_low_byte_next;
      bytes_left      <= bytes_left_next;
      at_packet_start <= at_packet_start_next;
      halted          <= halted_next;
    end
  end

endmodule

// ----- sv/lppd_out_reg.sv -----
module lppd_out_reg (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 advance,
  input  lppd_pkg::parse_out_t pout,
  output logic                 slot_free,
  output logic                 out_valid,
  input  logic                 out_ready,
  output lppd_pkg::result_t    res
);
  import lppd_pkg::*;

  // The slot can be loaded when empty or when its result is taken this cycle.
  assign slot_free = !out_valid || out_ready;

  // Result valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= pout.emit;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (advance && pout.emit) begin
      res <= pout.res;
    end
  end

endmodule

// ----- sv/length_prefixed_packet_deframer.sv -----
// Channel  | Handshake              | Payload
// ---------+------------------------+------------------------------------------
// input    | in_valid / in_ready    | in_byte
// result   | out_valid / out_ready  | kind, body_byte, first_of_packet,
//          |                        | last_of_packet
// config   | cfg_wr_en              | cfg_wr_data (max_total_length)
//
// One byte is taken per cycle while the result register is not stalled; a byte
// passes from its input transaction into the input register, then through the
// parser into the result register. The parser updates the header and counter
// state per byte. Synchronous reset clears the framing state, the maximum length
// to 65535, and both register stages. A stalled result holds the pipe; while the
// result register is being drained a new byte still enters in the same cycle.
module length_prefixed_packet_deframer (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [lppd_pkg::ByteW-1:0]  in_byte,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [lppd_pkg::KindW-1:0]  kind,
  output logic [lppd_pkg::ByteW-1:0]  body_byte,
  output logic                        first_of_packet,
  output logic                        last_of_packet,
  input  logic                        cfg_wr_en,
  input  logic [lppd_pkg::LenW-1:0]   cfg_wr_data
);
  import lppd_pkg::*;

  logic             hold_valid;
  logic [ByteW-1:0] hold_byte;
  logic             slot_free;
  logic             advance;
  logic [LenW-1:0]  max_total_length;
  parse_out_t       pout;
  result_t          res;

  // A byte moves on when the result slot can take whatever it produces.
  assign advance = hold_valid && slot_free;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      max_total_length <= MaxLenDefault;
    end else if (cfg_wr_en) begin
      max_total_length <= cfg_wr_data;
    end
  end

  lppd_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_byte    (in_byte),
    .advance    (advance),
    .hold_valid (hold_valid),
    .hold_byte  (hold_byte)
  );

  lppd_parse u_parse (
    .clk      (clk),
    .rst      (rst),
    .advance  (advance),
    .cur_byte (hold_byte),
    .max_len  (max_total_length),
    .pout     (pout)
  );

  lppd_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .pout      (pout),
    .slot_free (slot_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .res       (res)
  );

  // Result fields onto their ports.
  assign kind            = res.kind;
  assign body_byte       = res.body_byte;
  assign first_of_packet = res.first_of_packet;
  assign last_of_packet  = res.last_of_packet;

endmodule
